FILE: hw/rtl/ctgu_pkg.sv
// Shared types and constants for the Clifford tableau gate update block.
// Used by ctgu_ctrl, ctgu_dp and clifford_tableau_gate_update_top.
package ctgu_pkg;

  localparam int MaxQubitsDef     = 64;
  localparam int MaxGateQubitsDef = 3;

  localparam int RowW     = 64;
  localparam int RowIdxW  = 7;
  localparam int QcW      = 7;
  localparam int TgtW     = 6;
  localparam int KW       = 2;
  localparam int ActW     = 2;
  localparam int StatW    = 2;
  localparam int SlotW    = 8;
  localparam int LocW     = 3;
  localparam int ImgW     = 2 * LocW * SlotW;
  localparam int WordW    = 2 * RowW + 1;

  localparam int InDataW  = 208;
  localparam int OutDataW = 136;

  localparam logic [QcW-1:0] QubitCountReset = 7'd64;

  localparam logic [ActW-1:0] ActWrite = 2'd0;
  localparam logic [ActW-1:0] ActRead  = 2'd1;
  localparam logic [ActW-1:0] ActGate  = 2'd2;

  localparam logic [StatW-1:0] StatusOk        = 2'd0;
  localparam logic [StatW-1:0] StatusBadTarget = 2'd1;
  localparam logic [StatW-1:0] StatusBadRow    = 2'd2;

  typedef struct packed {
    logic               cap;
    logic               wr_row;
    logic               rd_row;
    logic               rd_gate;
    logic [RowIdxW-1:0] gate_addr;
    logic               res_load;
  } ctgu_cmd_t;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic             row_bad;
    logic             tgt_bad;
    logic [RowIdxW:0] row_total;
  } ctgu_stat_t;

endpackage

FILE: hw/rtl/ctgu_ctrl.sv
// Sequencer for the tableau block: handshakes, dispatch and the row sweep of a gate.
// Depends on ctgu_pkg; drives ctgu_dp through ctgu_cmd_t.
module ctgu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  input  ctgu_pkg::ctgu_stat_t st_i,
  output ctgu_pkg::ctgu_cmd_t  cmd_o
);
  import ctgu_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDisp   = 3'd1;
  localparam logic [2:0] StGate   = 3'd2;
  localparam logic [2:0] StDrain1 = 3'd3;
  localparam logic [2:0] StDrain2 = 3'd4;
  localparam logic [2:0] StResp   = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [RowIdxW-1:0] cnt_q, cnt_d;
  logic               out_vld_q, out_vld_d;
  logic               last_row;

  assign s_ready_o = (state_q == StIdle);
  assign m_valid_o = out_vld_q;
  assign last_row  = ({1'b0, cnt_q} == (st_i.row_total - 8'd1));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    out_vld_d = out_vld_q & ~m_ready_i;
    cmd_o     = '0;
    cmd_o.gate_addr = cnt_q;
    case (state_q)
      StIdle: begin
        if (s_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = StDisp;
        end
      end
      StDisp: begin
        state_d = StResp;
        case (st_i.action)
          ActWrite: cmd_o.wr_row = ~st_i.row_bad;
          ActRead:  cmd_o.rd_row = ~st_i.row_bad;
          ActGate: begin
            if (!st_i.tgt_bad) begin
              cnt_d   = '0;
              state_d = StGate;
            end
          end
          default: state_d = StResp;
        endcase
      end
      StGate: begin
        cmd_o.rd_gate = 1'b1;
        if (last_row) begin
          state_d = StDrain1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StDrain1: state_d = StDrain2;
      StDrain2: state_d = StResp;
      StResp: begin
        // hold until the output register is free
        if (!out_vld_q || m_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_vld_d      = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (!out_vld_q || m_ready_i))
    else $error("result loaded over a pending word");

  a_gate_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_gate |-> ({1'b0, cmd_o.gate_addr} < st_i.row_total))
    else $error("gate sweep beyond tableau rows");

  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> (state_q == StDisp))
    else $error("accepted word not dispatched");

  a_no_dual_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.rd_gate && (cmd_o.wr_row || cmd_o.rd_row || cmd_o.cap)))
    else $error("gate sweep overlaps another row access");

endmodule

FILE: hw/rtl/ctgu_dp.sv
// Datapath of the tableau block: item and config registers, row memory, row and
// target checks, gate row pipeline (read, combine images, write) and result register.
// Depends on ctgu_pkg; steered by ctgu_ctrl.
module ctgu_dp #(
  parameter int MAX_QUBITS      = ctgu_pkg::MaxQubitsDef,
  parameter int MAX_GATE_QUBITS = ctgu_pkg::MaxGateQubitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ctgu_pkg::QcW-1:0]      cfg_qc_i,
  input  logic [ctgu_pkg::ActW-1:0]     in_action_i,
  input  logic [ctgu_pkg::RowIdxW-1:0]  in_row_index_i,
  input  logic [ctgu_pkg::RowW-1:0]     in_row_x_i,
  input  logic [ctgu_pkg::RowW-1:0]     in_row_z_i,
  input  logic                          in_row_sign_i,
  input  logic [ctgu_pkg::KW-1:0]       in_target_count_i,
  input  logic [ctgu_pkg::TgtW-1:0]     in_target_a_i,
  input  logic [ctgu_pkg::TgtW-1:0]     in_target_b_i,
  input  logic [ctgu_pkg::TgtW-1:0]     in_target_c_i,
  input  logic [ctgu_pkg::ImgW-1:0]     in_images_i,
  input  ctgu_pkg::ctgu_cmd_t           cmd_i,
  output ctgu_pkg::ctgu_stat_t          st_o,
  output logic [ctgu_pkg::StatW-1:0]    res_status_o,
  output logic [ctgu_pkg::RowW-1:0]     res_x_o,
  output logic [ctgu_pkg::RowW-1:0]     res_z_o,
  output logic                          res_sign_o
);
  import ctgu_pkg::*;

  localparam int Depth = 2 * MAX_QUBITS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  function automatic logic [1:0] pop3(input logic [LocW-1:0] v);
    pop3 = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
  endfunction

  // configuration
  logic [QcW-1:0] qc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qc_q <= QubitCountReset;
    end else if (cfg_we_i) begin
      qc_q <= cfg_qc_i;
    end
  end

  // captured item
  logic [ActW-1:0]    act_q;
  logic [RowIdxW-1:0] row_q;
  logic [RowW-1:0]    wx_q, wz_q;
  logic               wsign_q;
  logic [KW-1:0]      k_q;
  logic [TgtW-1:0]    tq_q [LocW];
  logic [ImgW-1:0]    img_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      act_q   <= in_action_i;
      row_q   <= in_row_index_i;
      wx_q    <= in_row_x_i;
      wz_q    <= in_row_z_i;
      wsign_q <= in_row_sign_i;
      k_q     <= in_target_count_i;
      tq_q[0] <= in_target_a_i;
      tq_q[1] <= in_target_b_i;
      tq_q[2] <= in_target_c_i;
      img_q   <= in_images_i;
    end
  end

  // item checks
  logic [QcW-1:0]  n_use;
  logic [RowIdxW:0] row_total;
  logic            row_bad, tgt_bad;
  logic [LocW-1:0] lmask;

  always_comb begin
    if (qc_q == '0) begin
      n_use = 7'd1;
    end else if (qc_q > QcW'(MAX_QUBITS)) begin
      n_use = QcW'(MAX_QUBITS);
    end else begin
      n_use = qc_q;
    end
    row_total = {n_use, 1'b0};
    row_bad   = ({1'b0, row_q} >= row_total);
    tgt_bad   = (k_q == '0) || (k_q > KW'(MAX_GATE_QUBITS));
    for (int j = 0; j < LocW; j++) begin
      lmask[j] = (k_q > KW'(j));
      if (lmask[j]) begin
        if ({1'b0, tq_q[j]} >= n_use) tgt_bad = 1'b1;
        for (int m = 0; m < j; m++) begin
          if (tq_q[m] == tq_q[j]) tgt_bad = 1'b1;
        end
      end
    end
  end

  assign st_o.action    = act_q;
  assign st_o.row_bad   = row_bad;
  assign st_o.tgt_bad   = tgt_bad;
  assign st_o.row_total = row_total;

  // row memory: one read and one write port, registered read
  logic [WordW-1:0]   mem_q [Depth];
  logic [WordW-1:0]   rd_q;
  logic               rd_en, mem_we;
  logic [RowIdxW-1:0] rd_addr, wr_addr;
  logic [WordW-1:0]   wr_data;

  logic               e_vld_q;
  logic [RowIdxW-1:0] e_addr_q;
  logic               w_vld_q;
  logic [RowIdxW-1:0] w_addr_q;
  logic [WordW-1:0]   w_row_q;
  logic [LocW-1:0]    w_ax_q, w_az_q;
  logic               w_flip_q;

  assign rd_en   = cmd_i.rd_row | cmd_i.rd_gate;
  assign rd_addr = cmd_i.rd_row ? row_q : cmd_i.gate_addr;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[rd_addr[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr[AddrW-1:0]] <= wr_data;
    end
  end

  // combine stage: gather target bits and multiply the selected images
  logic [LocW-1:0]  lx, lz, ax, az, bx, bz;
  logic [1:0]       ph, bp, pcnt, resid;
  logic [SlotW-1:0] slot;
  logic             sel;

  always_comb begin
    lx = '0;
    lz = '0;
    for (int j = 0; j < LocW; j++) begin
      if (lmask[j]) begin
        lx[j] = rd_q[tq_q[j]];
        lz[j] = rd_q[RowW + int'(tq_q[j])];
      end
    end
    ax   = '0;
    az   = '0;
    ph   = '0;
    bx   = '0;
    bz   = '0;
    bp   = '0;
    pcnt = '0;
    slot = '0;
    sel  = 1'b0;
    for (int j = 0; j < LocW; j++) begin
      for (int w = 0; w < 2; w++) begin
        sel = (w == 0) ? lx[j] : lz[j];
        if (sel) begin
          slot = img_q[SlotW * (2 * j + w) +: SlotW];
          bx   = slot[2:0] & lmask;
          bz   = slot[5:3] & lmask;
          bp   = slot[7:6];
          pcnt = pop3(az & bx);
          ph   = ph + bp + (pcnt << 1);
          ax   = ax ^ bx;
          az   = az ^ bz;
        end
      end
    end
    ph    = ph + pop3(lx & lz);
    resid = ph - pop3(ax & az);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      w_vld_q <= 1'b0;
    end else begin
      e_vld_q <= cmd_i.rd_gate;
      // drop rows that carry nothing on the targets
      w_vld_q <= e_vld_q & (|{lx, lz});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_gate) begin
      e_addr_q <= cmd_i.gate_addr;
    end
    if (e_vld_q) begin
      w_addr_q <= e_addr_q;
      w_row_q  <= rd_q;
      w_ax_q   <= ax;
      w_az_q   <= az;
      w_flip_q <= (resid == 2'd2);
    end
  end

  // write stage: scatter the new local bits back into the row
  logic [RowW-1:0] nx, nz;
  always_comb begin
    nx = w_row_q[RowW-1:0];
    nz = w_row_q[2*RowW-1:RowW];
    for (int j = 0; j < LocW; j++) begin
      if (lmask[j]) begin
        nx[tq_q[j]] = w_ax_q[j];
        nz[tq_q[j]] = w_az_q[j];
      end
    end
  end

  assign mem_we  = cmd_i.wr_row | w_vld_q;
  assign wr_addr = cmd_i.wr_row ? row_q : w_addr_q;
  assign wr_data = cmd_i.wr_row ? {wsign_q, wz_q, wx_q}
                                : {w_row_q[WordW-1] ^ w_flip_q, nz, nx};

  // result register
  logic             rd_ok;
  logic [StatW-1:0] status;

  always_comb begin
    rd_ok = (act_q == ActRead) && !row_bad;
    case (act_q)
      ActWrite, ActRead: status = row_bad ? StatusBadRow : StatusOk;
      ActGate:           status = tgt_bad ? StatusBadTarget : StatusOk;
      default:           status = StatusOk;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_o <= status;
      res_x_o      <= rd_ok ? rd_q[RowW-1:0] : '0;
      res_z_o      <= rd_ok ? rd_q[2*RowW-1:RowW] : '0;
      res_sign_o   <= rd_ok & rd_q[WordW-1];
    end
  end

endmodule

FILE: hw/rtl/clifford_tableau_gate_update_top.sv
// Top level of the stabilizer tableau Clifford gate update block.
// Depends on ctgu_pkg, ctgu_ctrl and ctgu_dp.
//
// The block holds a tableau of 2n rows (n from the qubit count register) and
// takes one word at a time: write row, read row, or apply a gate given by
// the images of X_j and Z_j on up to three target qubits. Every word returns
// exactly one result word. A row write or read passes through dispatch to the
// result register; a gate sweeps all 2n rows and then drains the pipeline. The
// row memory reads one row and writes back an updated row each cycle in a
// three-step read, combine, write pipeline. A finished result waits in an
// output register, so the next word is accepted while it is pending. The
// tableau is not cleared at reset; rows must be written before they are read
// or swept by a gate. Write the qubit count only while the block is idle.
module clifford_tableau_gate_update_top #(
  parameter int MAX_QUBITS      = ctgu_pkg::MaxQubitsDef,
  parameter int MAX_GATE_QUBITS = ctgu_pkg::MaxGateQubitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config: qubit_count
  input  logic                          cfg_we_i,
  input  logic [ctgu_pkg::QcW-1:0]      cfg_wdata_i,
  // tdata: row_index, row_x, row_z, row_sign, target_count, target_a,
  //        target_b, target_c, images, zero pad
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ctgu_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: action
  input  logic [ctgu_pkg::ActW-1:0]     s_axis_tuser,
  // tdata: out_x, out_z, out_sign, zero pad
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ctgu_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: status
  output logic [ctgu_pkg::StatW-1:0]    m_axis_tuser
);
  import ctgu_pkg::*;

  ctgu_cmd_t       cmd;
  ctgu_stat_t      st;
  logic [RowW-1:0] res_x, res_z;
  logic            res_sign;

  ctgu_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  ctgu_dp #(
    .MAX_QUBITS      (MAX_QUBITS),
    .MAX_GATE_QUBITS (MAX_GATE_QUBITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_qc_i          (cfg_wdata_i),
    .in_action_i       (s_axis_tuser),
    .in_row_index_i    (s_axis_tdata[6:0]),
    .in_row_x_i        (s_axis_tdata[70:7]),
    .in_row_z_i        (s_axis_tdata[134:71]),
    .in_row_sign_i     (s_axis_tdata[135]),
    .in_target_count_i (s_axis_tdata[137:136]),
    .in_target_a_i     (s_axis_tdata[143:138]),
    .in_target_b_i     (s_axis_tdata[149:144]),
    .in_target_c_i     (s_axis_tdata[155:150]),
    .in_images_i       (s_axis_tdata[203:156]),
    .cmd_i             (cmd),
    .st_o              (st),
    .res_status_o      (m_axis_tuser),
    .res_x_o           (res_x),
    .res_z_o           (res_z),
    .res_sign_o        (res_sign)
  );

  assign m_axis_tdata = {7'd0, res_sign, res_z, res_x};

endmodule

FILE: test/clifford_tableau_gate_update_top_tb.sv
// Testbench for clifford_tableau_gate_update_top: row writes, row reads and gate updates,
// checked against a tableau predictor in this file or against fixed expected results.
// Depends on ctgu_pkg and the RTL of the block.
module clifford_tableau_gate_update_top_tb;
  import ctgu_pkg::*;

  localparam logic [ActW-1:0] ActSpare = 2'd3;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 2 * MaxQubitsDef + 12;
  localparam int PhaseWords    = 150;

  typedef struct packed {
    logic [ActW-1:0]    action;
    logic [RowIdxW-1:0] row;
    logic [RowW-1:0]    rx;
    logic [RowW-1:0]    rz;
    logic               rs;
    logic [KW-1:0]      k;
    logic [TgtW-1:0]    ta;
    logic [TgtW-1:0]    tb;
    logic [TgtW-1:0]    tc;
    logic [ImgW-1:0]    img;
  } tab_word_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [RowW-1:0]  ox;
    logic [RowW-1:0]  oz;
    logic             os;
  } row_result_t;

  typedef struct packed {
    logic           is_cfg;
    logic [QcW-1:0] qc;
    logic           typed;
    tab_word_t      w;
    row_result_t    want;
  } dir_step_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [QcW-1:0]      cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [ActW-1:0]     s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatW-1:0]    m_axis_tuser;

  clifford_tableau_gate_update_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // predictor copy of the tableau and the qubit count
  logic [RowW-1:0] x_tab [2*MaxQubitsDef];
  logic [RowW-1:0] z_tab [2*MaxQubitsDef];
  logic            s_tab [2*MaxQubitsDef];
  logic [QcW-1:0]  qubit_reg;

  row_result_t row_results_q [$];
  dir_step_t   dir_tab [$];
  int          fails;
  int          stall_cycles;
  bit          calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int qubits_used();
    if (qubit_reg == 0) return 1;
    if (qubit_reg > MaxQubitsDef) return MaxQubitsDef;
    return int'(qubit_reg);
  endfunction

  // Conjugate every row that touches the targets by the gate images.
  function automatic void conjugate_rows(input logic [2:0][TgtW-1:0] tq, input int k,
                                         input logic [ImgW-1:0] img);
    logic [2:0] lx, lz, ax, az, bx, bz, sel, lmask;
    logic [1:0] ph, resid;
    logic [SlotW-1:0] slot;
    lmask = 3'((1 << k) - 1);
    for (int r = 0; r < 2 * qubits_used(); r++) begin
      lx = '0;
      lz = '0;
      for (int j = 0; j < k; j++) begin
        lx[j] = x_tab[r][tq[j]];
        lz[j] = z_tab[r][tq[j]];
      end
      if (lx == 0 && lz == 0) continue;
      ax = '0;
      az = '0;
      ph = '0;
      for (int j = 0; j < k; j++) begin
        for (int w = 0; w < 2; w++) begin
          sel = (w == 0) ? lx : lz;
          if (!sel[j]) continue;
          slot = img[SlotW*(2*j+w) +: SlotW];
          bx = slot[2:0] & lmask;
          bz = slot[5:3] & lmask;
          ph = 2'(ph + slot[7:6] + 2 * $countones(az & bx));
          ax ^= bx;
          az ^= bz;
        end
      end
      ph = 2'(ph + $countones(lx & lz));
      resid = 2'(ph - $countones(ax & az));
      if (resid == 2'd2) s_tab[r] = ~s_tab[r];
      for (int j = 0; j < k; j++) begin
        x_tab[r][tq[j]] = ax[j];
        z_tab[r][tq[j]] = az[j];
      end
    end
  endfunction

  function automatic row_result_t tableau_step(input tab_word_t w);
    row_result_t res;
    logic [2:0][TgtW-1:0] tq;
    bit ok;
    int k;
    res = '0;
    tq = {w.tc, w.tb, w.ta};
    k = int'(w.k);
    if (w.action == ActWrite || w.action == ActRead) begin
      if (int'(w.row) >= 2 * qubits_used()) begin
        res.status = StatusBadRow;
      end else if (w.action == ActWrite) begin
        x_tab[w.row] = w.rx;
        z_tab[w.row] = w.rz;
        s_tab[w.row] = w.rs;
      end else begin
        res.ox = x_tab[w.row];
        res.oz = z_tab[w.row];
        res.os = s_tab[w.row];
      end
    end else if (w.action == ActGate) begin
      ok = (k >= 1 && k <= MaxGateQubitsDef);
      for (int j = 0; j < k; j++) begin
        if (int'(tq[j]) >= qubits_used()) ok = 0;
        for (int m = 0; m < j; m++)
          if (tq[m] == tq[j]) ok = 0;
      end
      if (ok) conjugate_rows(tq, k, w.img);
      else res.status = StatusBadTarget;
    end
    return res;
  endfunction

  function automatic tab_word_t wr_word(input logic [RowIdxW-1:0] row, input logic [RowW-1:0] x,
                                        input logic [RowW-1:0] z, input logic s);
    tab_word_t w;
    w = '0;
    w.action = ActWrite;
    w.row = row;
    w.rx = x;
    w.rz = z;
    w.rs = s;
    return w;
  endfunction

  function automatic tab_word_t rd_word(input logic [RowIdxW-1:0] row);
    tab_word_t w;
    w = '0;
    w.action = ActRead;
    w.row = row;
    return w;
  endfunction

  function automatic tab_word_t gate_word(input logic [KW-1:0] k, input logic [TgtW-1:0] a,
                                          input logic [TgtW-1:0] b, input logic [TgtW-1:0] c,
                                          input logic [ImgW-1:0] img);
    tab_word_t w;
    w = '0;
    w.action = ActGate;
    w.k = k;
    w.ta = a;
    w.tb = b;
    w.tc = c;
    w.img = img;
    return w;
  endfunction

  function automatic row_result_t row_res(input logic [StatW-1:0] st, input logic [RowW-1:0] x,
                                          input logic [RowW-1:0] z, input logic s);
    row_result_t r;
    r.status = st;
    r.ox = x;
    r.oz = z;
    r.os = s;
    return r;
  endfunction

  function automatic void add_cfg(input logic [QcW-1:0] v);
    dir_step_t st;
    st = '0;
    st.is_cfg = 1'b1;
    st.qc = v;
    dir_tab = {dir_tab, st};
  endfunction

  function automatic void add_word(input tab_word_t w, input bit typed, input row_result_t want);
    dir_step_t st;
    st = '0;
    st.typed = typed;
    st.w = w;
    st.want = want;
    dir_tab = {dir_tab, st};
  endfunction

  function automatic logic [RowW-1:0] rand_row_bits();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed words within the current qubit count, some noise.
  function automatic tab_word_t random_word(input int nq);
    tab_word_t w;
    int pick;
    int kmax;
    pick = $urandom_range(0, 99);
    w.action = (pick < 30) ? ActWrite : (pick < 58) ? ActRead : (pick < 95) ? ActGate : ActSpare;
    if ($urandom_range(0, 6) != 0) w.row = 7'($urandom_range(0, 2 * nq - 1));
    else w.row = 7'($urandom_range(0, 127));
    w.rx = rand_row_bits();
    w.rz = rand_row_bits();
    w.rs = 1'($urandom);
    w.img = 48'({$urandom, $urandom});
    w.ta = 6'($urandom);
    w.tb = 6'($urandom);
    w.tc = 6'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      w.k = 2'($urandom);
    end else begin
      kmax = (nq < 3) ? nq : 3;
      w.k = 2'($urandom_range(1, kmax));
      w.ta = 6'($urandom_range(0, nq - 1));
      if (w.k >= 2) begin
        do w.tb = 6'($urandom_range(0, nq - 1)); while (w.tb == w.ta);
      end
      if (w.k == 3) begin
        do w.tc = 6'($urandom_range(0, nq - 1)); while (w.tc == w.ta || w.tc == w.tb);
      end
    end
    return w;
  endfunction

  // Present one word, hold it until taken, then queue its expected result.
  task automatic send_word(input tab_word_t w, input bit typed, input row_result_t want);
    int gap;
    row_result_t pred;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= w.action;
    s_axis_tdata  <= {4'b0, w.img, w.tc, w.tb, w.ta, w.k, w.rs, w.rz, w.rx, w.row};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = tableau_step(w);
    row_results_q = {row_results_q, (typed ? want : pred)};
  endtask

  // Drop valid and let the block drain before touching the register.
  task automatic set_qubits(input logic [QcW-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (row_results_q.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    qubit_reg = v;
  endtask

  task automatic check_field(input string name, input logic [RowW-1:0] exp_v,
                             input logic [RowW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      int stall;
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    row_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (row_results_q.size() == 0) begin
        $display("%0t: result with nothing pending, status %0d", $time, m_axis_tuser);
        fails++;
      end else begin
        want = row_results_q.pop_front();
        check_field("status", 64'(want.status), 64'(m_axis_tuser));
        check_field("out_x", want.ox, m_axis_tdata[63:0]);
        check_field("out_z", want.oz, m_axis_tdata[127:64]);
        check_field("out_sign", 64'(want.os), 64'(m_axis_tdata[128]));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [QcW-1:0] phase_qc [10];
    fails = 0;
    stall_cycles = 0;
    calm = 1'b0;
    qubit_reg = QubitCountReset;
    for (int r = 0; r < 2 * MaxQubitsDef; r++) begin
      x_tab[r] = '0;
      z_tab[r] = '0;
      s_tab[r] = 1'b0;
    end
    phase_qc = '{7'd64, 7'd1, 7'd2, 7'd3, 7'd6, 7'd0, 7'd127, 7'd20, 7'd45, 7'd64};
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ActWrite;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_qubits(7'd64);
    // fill every row so that reads and gate sweeps only see written rows
    for (int r = 0; r < 2 * MaxQubitsDef; r++)
      send_word(wr_word(7'(r), {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom)),
                1'b0, '0);

    add_word(wr_word(7'd0, '1, '0, 1'b1), 1, row_res(StatusOk, '0, '0, 1'b0));
    add_word(rd_word(7'd0), 1, row_res(StatusOk, '1, '0, 1'b1));
    add_word(wr_word(7'd127, '0, '1, 1'b0), 1, row_res(StatusOk, '0, '0, 1'b0));
    add_word(rd_word(7'd127), 1, row_res(StatusOk, '0, '1, 1'b0));
    add_word(gate_word(2'd0, 6'd0, 6'd1, 6'd2, '0), 1, row_res(StatusBadTarget, '0, '0, 1'b0));
    // Hadamard on the top qubit
    add_word(gate_word(2'd1, 6'd63, 6'd0, 6'd0, 48'h01_08), 0, '0);
    add_word(rd_word(7'd0), 0, '0);
    add_word(gate_word(2'd2, 6'd5, 6'd5, 6'd0, '1), 1, row_res(StatusBadTarget, '0, '0, 1'b0));
    add_word(gate_word(2'd3, 6'd1, 6'd2, 6'd1, '1), 1, row_res(StatusBadTarget, '0, '0, 1'b0));
    add_word(gate_word(2'd3, 6'd0, 6'd31, 6'd63, '1), 0, '0);
    // odd phase on X image, stray x bit above k
    add_word(gate_word(2'd2, 6'd62, 6'd63, 6'd0, 48'h10_02_08_45), 0, '0);
    add_word(gate_word(2'd0, 6'd0, 6'd0, 6'd0, '0) | tab_word_t'(0), 0, '0);
    dir_tab[dir_tab.size()-1].w.action = ActSpare;
    dir_tab[dir_tab.size()-1].typed = 1'b1;
    add_word(rd_word(7'd127), 0, '0);
    add_cfg(7'd4);
    add_word(wr_word(7'd8, '1, '1, 1'b1), 1, row_res(StatusBadRow, '0, '0, 1'b0));
    add_word(rd_word(7'd8), 1, row_res(StatusBadRow, '0, '0, 1'b0));
    add_word(rd_word(7'd7), 0, '0);
    add_word(gate_word(2'd1, 6'd4, 6'd0, 6'd0, '0), 1, row_res(StatusBadTarget, '0, '0, 1'b0));
    // CNOT with control on qubit 3
    add_word(gate_word(2'd2, 6'd3, 6'd0, 6'd0, 48'h18_02_08_03), 0, '0);
    add_cfg(7'd0);
    add_word(rd_word(7'd2), 1, row_res(StatusBadRow, '0, '0, 1'b0));
    add_word(rd_word(7'd1), 0, '0);
    add_word(gate_word(2'd1, 6'd1, 6'd0, 6'd0, '0), 1, row_res(StatusBadTarget, '0, '0, 1'b0));
    // phase gate: X goes to Y
    add_word(gate_word(2'd1, 6'd0, 6'd0, 6'd0, 48'h08_49), 0, '0);
    add_cfg(7'd127);
    add_word(gate_word(2'd3, 6'd63, 6'd62, 6'd61, 48'h9A_3C_E1_57_C6_2B), 0, '0);
    add_word(rd_word(7'd126), 0, '0);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) set_qubits(dir_tab[i].qc);
      else send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].want);
    end

    foreach (phase_qc[p]) begin
      set_qubits(phase_qc[p]);
      for (int i = 0; i < PhaseWords; i++) begin
        calm = ((i / 25) % 4 == 3);
        send_word(random_word(qubits_used()), 1'b0, '0);
      end
    end

    calm = 1'b0;
    s_axis_tvalid <= 1'b0;
    while (row_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ctgu_pkg.sv
hw/rtl/ctgu_ctrl.sv
hw/rtl/ctgu_dp.sv
hw/rtl/clifford_tableau_gate_update_top.sv
test/clifford_tableau_gate_update_top_tb.sv
